@@ sv/nmbf_pkg.sv @@
// ----------------------------------------------------------------------------
// nmbf_pkg: shared types and constants for the named mailbox FIFO block
// Holds payload structs, action and status codes, and sizing constants.
// ----------------------------------------------------------------------------
package nmbf_pkg;

	localparam int NUM_BOXES  = 32;
	localparam int FIFO_DEPTH = 64;
	localparam int NAME_CHARS = 15;
	localparam int BOX_W      = $clog2(NUM_BOXES);
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);
	localparam int MEM_W      = BOX_W + PTR_W;
	localparam int NAME_W     = 120;

	localparam logic [1:0] ACT_OPEN  = 2'd0;
	localparam logic [1:0] ACT_CLOSE = 2'd1;
	localparam logic [1:0] ACT_SEND  = 2'd2;
	localparam logic [1:0] ACT_RECV  = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_EMPTY   = 3'd2;
	localparam logic [2:0] ST_NO_FREE = 3'd3;
	localparam logic [2:0] ST_NOT_OPN = 3'd4;
	localparam logic [2:0] ST_SAT     = 3'd5;

	typedef struct packed {
		logic [1:0]  action;
		logic [4:0]  box_id;
		logic [63:0] name_low;
		logic [55:0] name_high;
		logic [7:0]  data_in;
		logic        end_of_message;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [4:0] result_box;
		logic [7:0] data_out;
		logic [7:0] users_left;
		logic       last_out;
	} rsp_t;

	// classified command handed from front to back
	typedef struct packed {
		logic [1:0]        action;
		logic [4:0]        box_id;
		logic [NAME_W-1:0] name;
		logic              hit;
		logic [BOX_W-1:0]  hit_box;
		logic              has_free;
		logic [BOX_W-1:0]  free_box;
		logic [7:0]        data_in;
		logic              last;
	} cmd_t;

	// cut name at first zero character and at NAME_CHARS characters
	function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_W-1:0] raw);
		logic [NAME_W-1:0] o;
		logic              live;
		o    = '0;
		live = 1'b1;
		for (int k = 0; k < 15; k++) begin
			if (raw[8*k +: 8] == 8'd0 || k >= NAME_CHARS)
				live = 1'b0;
			if (live)
				o[8*k +: 8] = raw[8*k +: 8];
		end
		return o;
	endfunction

endpackage

@@ sv/nmbf_front.sv @@
// ----------------------------------------------------------------------------
// nmbf_front: request intake and name classification
// Normalizes names, matches them against open boxes, finds the first free box.
// ----------------------------------------------------------------------------
module nmbf_front import nmbf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  req_t                 in_data,
	input  logic [NUM_BOXES-1:0] used,
	input  logic [NAME_W-1:0]    names [NUM_BOXES],
	input  logic                 busy,
	output logic                 cmd_valid,
	input  logic                 cmd_stall,
	output cmd_t                 cmd
);

	logic [NAME_W-1:0] nm;
	logic              hit;
	logic [BOX_W-1:0]  hit_box;
	logic              has_free;
	logic [BOX_W-1:0]  free_box;

	// one item in flight: the table must settle before the next lookup
	assign in_stall = busy;

	assign nm = norm_name({in_data.name_high, in_data.name_low});

	// priority match and free search, lowest index wins
	always_comb begin
		hit      = 1'b0;
		hit_box  = '0;
		has_free = 1'b0;
		free_box = '0;
		for (int b = NUM_BOXES - 1; b >= 0; b--) begin
			if (used[b] && names[b] == nm) begin
				hit     = 1'b1;
				hit_box = BOX_W'(b);
			end
			if (!used[b]) begin
				has_free = 1'b1;
				free_box = BOX_W'(b);
			end
		end
	end

	// command register toward the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (in_valid && !in_stall) begin
			cmd_valid <= 1'b1;
		end else if (!cmd_stall) begin
			cmd_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd.action   <= in_data.action;
			cmd.box_id   <= in_data.box_id;
			cmd.name     <= nm;
			cmd.hit      <= hit;
			cmd.hit_box  <= hit_box;
			cmd.has_free <= has_free;
			cmd.free_box <= free_box;
			cmd.data_in  <= in_data.data_in;
			cmd.last     <= in_data.end_of_message;
		end
	end

endmodule

@@ sv/nmbf_back.sv @@
// ----------------------------------------------------------------------------
// nmbf_back: box table and byte store execution
// Applies open, close, send and receive; drives the registered result.
// ----------------------------------------------------------------------------
module nmbf_back import nmbf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  cmd_t                 cmd,
	output logic [NUM_BOXES-1:0] used,
	output logic [NAME_W-1:0]    names [NUM_BOXES],
	output logic                 busy,
	output logic                 out_valid,
	input  logic                 out_stall,
	output rsp_t                 out_data
);

	logic [NUM_BOXES-1:0] used_q;
	logic [NAME_W-1:0]    name_q [NUM_BOXES];
	logic [7:0]           cnt_q  [NUM_BOXES];
	logic [PTR_W-1:0]     rd_q   [NUM_BOXES];
	logic [PTR_W-1:0]     wr_q   [NUM_BOXES];
	logic [LVL_W-1:0]     lvl_q  [NUM_BOXES];
	logic [7:0]           mem    [NUM_BOXES*FIFO_DEPTH];

	logic                 rd_pend_q;
	logic [7:0]           rd_data_q;
	logic                 out_valid_q;
	rsp_t                 rsp_q;

	logic                 take;
	logic                 in_range;
	logic [BOX_W-1:0]     bx;
	rsp_t                 rsp;
	logic                 do_wr;
	logic                 do_rd;
	logic [MEM_W-1:0]     waddr;
	logic [MEM_W-1:0]     raddr;

	assign used  = used_q;
	assign names = name_q;

	// stall while a result waits or a receive read is in flight
	assign cmd_stall = (out_valid_q && out_stall) || rd_pend_q;
	assign take      = cmd_valid && !cmd_stall;
	assign busy      = cmd_valid || rd_pend_q;

	assign in_range = (32'(cmd.box_id) < NUM_BOXES);
	assign bx       = BOX_W'(cmd.box_id);

	// decide the result and the memory access
	always_comb begin
		rsp            = '0;
		rsp.result_box = cmd.box_id;
		rsp.last_out   = cmd.last;
		do_wr          = 1'b0;
		do_rd          = 1'b0;
		waddr          = {bx, wr_q[bx]};
		raddr          = {bx, rd_q[bx]};
		if (cmd.action == ACT_OPEN) begin
			if (cmd.hit) begin
				rsp.result_box = 5'(cmd.hit_box);
				if (cnt_q[cmd.hit_box] == 8'd255) begin
					rsp.status     = ST_SAT;
					rsp.users_left = 8'd255;
				end else begin
					rsp.users_left = cnt_q[cmd.hit_box] + 8'd1;
				end
			end else if (cmd.has_free) begin
				rsp.result_box = 5'(cmd.free_box);
				rsp.users_left = 8'd1;
			end else begin
				rsp.status = ST_NO_FREE;
			end
		end else if (!in_range || !used_q[bx]) begin
			rsp.status = ST_NOT_OPN;
		end else if (cmd.action == ACT_CLOSE) begin
			rsp.users_left = cnt_q[bx] - 8'd1;
		end else if (cmd.action == ACT_SEND) begin
			rsp.users_left = cnt_q[bx];
			if (32'(lvl_q[bx]) >= FIFO_DEPTH)
				rsp.status = ST_FULL;
			else
				do_wr = 1'b1;
		end else begin
			rsp.users_left = cnt_q[bx];
			if (lvl_q[bx] == '0)
				rsp.status = ST_EMPTY;
			else
				do_rd = 1'b1;
		end
	end

	// box table update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			for (int b = 0; b < NUM_BOXES; b++) begin
				cnt_q[b] <= '0;
				rd_q[b]  <= '0;
				wr_q[b]  <= '0;
				lvl_q[b] <= '0;
			end
		end else if (take) begin
			if (cmd.action == ACT_OPEN) begin
				if (cmd.hit) begin
					if (cnt_q[cmd.hit_box] != 8'd255)
						cnt_q[cmd.hit_box] <= cnt_q[cmd.hit_box] + 8'd1;
				end else if (cmd.has_free) begin
					used_q[cmd.free_box] <= 1'b1;
					cnt_q[cmd.free_box]  <= 8'd1;
					rd_q[cmd.free_box]   <= '0;
					wr_q[cmd.free_box]   <= '0;
					lvl_q[cmd.free_box]  <= '0;
				end
			end else if (in_range && used_q[bx]) begin
				if (cmd.action == ACT_CLOSE) begin
					cnt_q[bx] <= cnt_q[bx] - 8'd1;
					if (cnt_q[bx] == 8'd1)
						used_q[bx] <= 1'b0;
				end else if (do_wr) begin
					wr_q[bx]  <= wr_q[bx] + PTR_W'(1);
					lvl_q[bx] <= lvl_q[bx] + LVL_W'(1);
				end else if (do_rd) begin
					rd_q[bx]  <= rd_q[bx] + PTR_W'(1);
					lvl_q[bx] <= lvl_q[bx] - LVL_W'(1);
				end
			end
		end
	end

	// names are written on allocation only
	always_ff @(posedge clk) begin
		if (take && cmd.action == ACT_OPEN && !cmd.hit && cmd.has_free)
			name_q[cmd.free_box] <= cmd.name;
	end

	// byte store, one write or one registered read per cycle
	always_ff @(posedge clk) begin
		if (take && do_wr)
			mem[waddr] <= cmd.data_in;
		if (take && do_rd)
			rd_data_q <= mem[raddr];
	end

	// result register, receive data merged in the cycle after the command is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rd_pend_q   <= 1'b0;
		end else begin
			rd_pend_q <= take && do_rd;
			if (take && !do_rd)
				out_valid_q <= 1'b1;
			else if (rd_pend_q)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			rsp_q <= rsp;
		else if (rd_pend_q)
			rsp_q.data_out <= rd_data_q;
	end

	assign out_valid = out_valid_q;
	assign out_data  = rsp_q;

	// a pending read never overlaps a new command
	assert property (@(posedge clk) disable iff (!arst_n) rd_pend_q |-> !take)
		else $error("command taken during pending read");
	// a receive result shows up in the cycle after the pending read
	assert property (@(posedge clk) disable iff (!arst_n) rd_pend_q |=> out_valid_q)
		else $error("receive result missing");
	// fill level never exceeds the fifo depth
	assert property (@(posedge clk) disable iff (!arst_n)
		take && do_wr |-> 32'(lvl_q[bx]) < FIFO_DEPTH)
		else $error("write into full fifo");

endmodule

@@ sv/named_mailbox_byte_fifos.sv @@
// ----------------------------------------------------------------------------
// named_mailbox_byte_fifos: table of named mailboxes with byte FIFOs
// Open, close, send and receive on 32 named boxes of 64 bytes each.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests enter on in_valid/in_stall/in_data; each transfer yields one
//    result on out_valid/out_stall/out_data.
//  - The front stage normalizes the name and runs the parallel name match
//    and free-box search in the transfer cycle; the command register then
//    feeds the back stage, which updates the box table.
//  - The request is registered in the command register, then its result in
//    the result register; a successful receive also waits on the registered
//    byte store read before its data is merged into the result.
//  - The front waits until the back has retired the item before it takes a
//    new request, since each lookup needs the updated table.
//  - Reset clears all boxes to free with empty FIFOs; no clearing pass.
//  - While out_stall is high and a result is pending, the result holds and
//    the back stage stops, which in turn stalls the input.
// ----------------------------------------------------------------------------
module named_mailbox_byte_fifos import nmbf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output rsp_t out_data
);

	logic                 cmd_valid;
	logic                 cmd_stall;
	cmd_t                 cmd;
	logic [NUM_BOXES-1:0] used;
	logic [NAME_W-1:0]    names [NUM_BOXES];
	logic                 busy;

	nmbf_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.used, .names, .busy, .cmd_valid, .cmd_stall, .cmd
	);

	nmbf_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd_stall, .cmd,
		.used, .names, .busy, .out_valid, .out_stall, .out_data
	);

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for named_mailbox_byte_fifos
// Drives open, close, send and receive transfers with random gaps and output
// stalls, predicts each response from a behavioral mailbox table, and checks
// every field of every response in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import nmbf_pkg::*;

	// behavioral mailbox table and response queue
	class mailbox_scoreboard;
		bit                in_use [NUM_BOXES];
		logic [NAME_W-1:0] box_nm [NUM_BOXES];
		int unsigned       users  [NUM_BOXES];
		int unsigned       rd_ix  [NUM_BOXES];
		int unsigned       wr_ix  [NUM_BOXES];
		int unsigned       level  [NUM_BOXES];
		logic [7:0]        bytes  [NUM_BOXES*FIFO_DEPTH];
		rsp_t              pending[$];
		int                errors;

		function new();
			errors = 0;
			for (int b = 0; b < NUM_BOXES; b++) clear(b);
		endfunction

		function void clear(int b);
			in_use[b] = 0; box_nm[b] = '0; users[b] = 0;
			rd_ix[b] = 0; wr_ix[b] = 0; level[b] = 0;
		endfunction

		function int open_count();
			int n;
			n = 0;
			for (int b = 0; b < NUM_BOXES; b++) n += int'(in_use[b]);
			return n;
		endfunction

		// predict the response for one accepted request
		function void note_request(req_t r);
			rsp_t              e;
			logic [NAME_W-1:0] nm;
			bit                found, live;
			int                id;
			e = '0;
			id = int'(r.box_id);
			e.result_box = r.box_id;
			e.last_out = r.end_of_message;
			if (r.action == ACT_OPEN) begin
				nm = '0;
				live = 1;
				for (int k = 0; k < 15; k++) begin
					logic [7:0] c;
					c = (k < 8) ? r.name_low[8*k +: 8] : r.name_high[8*(k-8) +: 8];
					if (c == 0 || k >= NAME_CHARS) live = 0;
					if (live) nm[8*k +: 8] = c;
				end
				found = 0;
				for (int b = 0; b < NUM_BOXES && !found; b++)
					if (in_use[b] && box_nm[b] == nm) begin
						found = 1;
						e.result_box = 5'(b);
						if (users[b] >= 255) e.status = ST_SAT;
						else users[b]++;
						e.users_left = 8'(users[b]);
					end
				if (!found) begin
					e.status = ST_NO_FREE;
					for (int b = 0; b < NUM_BOXES && e.status == ST_NO_FREE; b++)
						if (!in_use[b]) begin
							clear(b);
							in_use[b] = 1; box_nm[b] = nm; users[b] = 1;
							e.status = ST_OK; e.result_box = 5'(b); e.users_left = 8'd1;
						end
				end
			end else if (id >= NUM_BOXES || !in_use[id]) begin
				e.status = ST_NOT_OPN;
			end else if (r.action == ACT_CLOSE) begin
				users[id]--;
				e.users_left = 8'(users[id]);
				if (users[id] == 0) clear(id);
			end else if (r.action == ACT_SEND) begin
				e.users_left = 8'(users[id]);
				if (level[id] >= FIFO_DEPTH) e.status = ST_FULL;
				else begin
					bytes[id*FIFO_DEPTH + wr_ix[id]] = r.data_in;
					wr_ix[id] = (wr_ix[id] + 1) % FIFO_DEPTH;
					level[id]++;
				end
			end else begin
				e.users_left = 8'(users[id]);
				if (level[id] == 0) e.status = ST_EMPTY;
				else begin
					e.data_out = bytes[id*FIFO_DEPTH + rd_ix[id]];
					rd_ix[id] = (rd_ix[id] + 1) % FIFO_DEPTH;
					level[id]--;
				end
			end
			pending.push_back(e);
		endfunction

		task report(string what, int got, int want);
			errors++;
			$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		endtask

		// compare one response against the oldest prediction
		task check_response(rsp_t g);
			rsp_t e;
			if (pending.size() == 0) begin
				report("unexpected response", 1, 0);
				return;
			end
			e = pending.pop_front();
			if (g.status !== e.status) report("status", g.status, e.status);
			if (g.result_box !== e.result_box) report("result_box", g.result_box, e.result_box);
			if (g.data_out !== e.data_out) report("data_out", g.data_out, e.data_out);
			if (g.users_left !== e.users_left) report("users_left", g.users_left, e.users_left);
			if (g.last_out !== e.last_out) report("last_out", g.last_out, e.last_out);
		endtask
	endclass

	logic clk, arst_n, in_valid, in_stall, out_valid, out_stall;
	req_t in_data;
	rsp_t out_data;
	mailbox_scoreboard sb;
	bit   hold_rx;
	bit   rx_free_run;
	int   idle_cycles;
	logic [NAME_W-1:0] name_pool [8];

	named_mailbox_byte_fifos dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// note transfers on both channels, and watch for a stuck block
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_request(in_data);
			if (out_valid && !out_stall) sb.check_response(out_data);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_rx)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > 2000) begin
				$display("FAIL named_mailbox_byte_fifos");
				$finish;
			end
		end
	end

	// receiver: random stalls per response, long hold-off on request, no stalls in free-run mode
	initial begin
		int w;
		out_stall = 1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rx) out_stall <= 1;
			else if (rx_free_run) out_stall <= 0;
			else if (out_valid && !out_stall) begin
				w = $urandom_range(0, 16);
				if (w > 0) begin
					out_stall <= 1;
					repeat (w - 1) @(posedge clk);
					@(posedge clk);
				end
				out_stall <= 0;
			end else out_stall <= 0;
		end
	end

	// offer one request and wait for its transfer; valid stays up afterward
	task automatic send_request(req_t r, int gap);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		in_data  <= r;
		do @(posedge clk); while (in_stall);
	endtask

	function automatic req_t make_req(logic [1:0] act, int id, logic [NAME_W-1:0] nm,
			int d);
		req_t r;
		r.action = act;
		r.box_id = 5'(id);
		r.name_low = nm[63:0];
		r.name_high = nm[119:64];
		r.data_in = 8'(d);
		r.end_of_message = 1'($urandom_range(0, 1));
		return r;
	endfunction

	function automatic logic [NAME_W-1:0] rand_name();
		logic [NAME_W-1:0] n;
		n = NAME_W'({$urandom, $urandom, $urandom, $urandom});
		return n;
	endfunction

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		req_t r;
		int   a, id, pick;
		hold_rx = 0;
		rx_free_run = 0;
		idle_cycles = 0;
		sb = new();
		in_valid = 0;
		in_data = '0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		for (int i = 0; i < 8; i++) begin
			name_pool[i] = rand_name();
			// short names, zero-cut names and the empty name
			if (i < 3)
				name_pool[i] = name_pool[i] &
					((NAME_W'(1) << (8*(i+1))) - NAME_W'(1));
			if (i == 3) name_pool[i] = '0;
			if (i == 4) name_pool[i][8*5 +: 8] = 8'd0;
		end

		// directed: not-open cases, extremes and empty boxes
		send_request(make_req(ACT_CLOSE, 31, '0, 8'hff), 0);
		send_request(make_req(ACT_SEND, 0, '0, 8'hff), 0);
		send_request(make_req(ACT_RECV, 5, '0, 8'h00), 0);
		send_request(make_req(ACT_OPEN, 0, {NAME_W{1'b1}}, 8'h00), 0);
		send_request(make_req(ACT_OPEN, 31, {NAME_W{1'b1}}, 8'h00), 0);
		send_request(make_req(ACT_OPEN, 0, '0, 8'h00), 0);
		send_request(make_req(ACT_OPEN, 0, {8'd0, {14{8'h41}}}, 8'h00), 0);
		send_request(make_req(ACT_OPEN, 0, name_pool[4], 8'h00), 0);
		send_request(make_req(ACT_RECV, 0, '0, 8'h00), 0);
		send_request(make_req(ACT_SEND, 0, '0, 8'h00), 0);
		send_request(make_req(ACT_SEND, 0, '0, 8'hff), 0);
		send_request(make_req(ACT_RECV, 0, '0, 8'h00), 0);
		send_request(make_req(ACT_RECV, 0, '0, 8'h00), 0);
		send_request(make_req(ACT_RECV, 0, '0, 8'h00), 0);
		send_request(make_req(ACT_CLOSE, 0, '0, 8'h00), 0);
		send_request(make_req(ACT_CLOSE, 0, '0, 8'h00), 0);

		// fill box 1 past full while the receiver holds off
		hold_rx = 1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_rx = 0;
			end
			for (int i = 0; i < FIFO_DEPTH + 2; i++)
				send_request(make_req(ACT_SEND, 1, '0, $urandom), 0);
		join
		for (int i = 0; i < FIFO_DEPTH + 1; i++)
			send_request(make_req(ACT_RECV, 1, '0, 8'h00), $urandom_range(0, 2));
		drain();

		// take every free box, then further opens with nothing free
		for (int i = 0; i < NUM_BOXES + 1; i++)
			send_request(make_req(ACT_OPEN, $urandom, rand_name(), 8'h00), 0);
		// push the empty-name box count to saturation with no receiver stalls
		rx_free_run = 1;
		for (int i = 0; i < 260; i++)
			send_request(make_req(ACT_OPEN, 0, '0, 8'h00), 0);
		rx_free_run = 0;
		drain();
		// free everything: each box is closed until its count reaches zero
		for (int b = 0; b < NUM_BOXES; b++)
			while (sb.in_use[b] || sb.pending.size() != 0) begin
				if (sb.pending.size() != 0) begin
					in_valid <= 0;
					@(posedge clk);
				end else send_request(make_req(ACT_CLOSE, b, '0, 8'h00), 0);
			end

		// random traffic on a small name pool so boxes are shared
		for (int i = 0; i < 300; i++) begin
			a = $urandom_range(0, 9);
			id = (sb.open_count() > 0 && $urandom_range(0, 7) != 0) ?
				$urandom_range(0, 7) : $urandom_range(0, 31);
			pick = $urandom_range(0, 7);
			if (a < 2) r = make_req(ACT_OPEN, $urandom,
				($urandom_range(0, 9) == 0) ? rand_name() : name_pool[pick], $urandom);
			else if (a < 3) r = make_req(ACT_CLOSE, id, rand_name(), $urandom);
			else if (a < 7) r = make_req(ACT_SEND, id, rand_name(), $urandom);
			else r = make_req(ACT_RECV, id, rand_name(), $urandom);
			send_request(r, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
			if (i == 150) drain();
		end

		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASS named_mailbox_byte_fifos");
		else
			$display("FAIL named_mailbox_byte_fifos");
		$finish;
	end
endmodule
